FILE: hdl/dnle_pkg.sv
// Shared constants and types for the DNS name label encoder.
`timescale 1ns / 1ps
`default_nettype none
package dnle_pkg;

  localparam int LABEL_MAX = 62;
  localparam int NAME_MAX  = 255;

  // label character count / store index width
  localparam int CNT_W  = $clog2(LABEL_MAX + 1);
  localparam int LEN_W  = 9;
  localparam int ADDR_W = CNT_W + 1;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_LABEL = 2'd1;
  localparam logic [1:0] ERR_NAME  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic             has_label;
    logic [CNT_W-1:0] n;
    logic             bank;
    logic             term;
    logic [LEN_W-1:0] enc_len;
    logic [1:0]       err;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/dnle_front.sv
// Front end: accepts characters, buffers labels and issues replay commands.
`timescale 1ns / 1ps
`default_nettype none
module dnle_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [7:0]             in_char_in,
  input  wire                    in_end_of_name,
  input  wire                    busy,
  output dnle_pkg::mem_wr_t      mem_wr,
  output logic                   cmd_push,
  output dnle_pkg::cmd_t         cmd_data
);
  import dnle_pkg::*;

  logic [CNT_W-1:0] label_cnt_r, label_cnt_nxt;
  logic [LEN_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             bank_r, bank_nxt;

  logic             closer, accept, drop, cut;
  logic [LEN_W-1:0] room, room_m1, label_ext, n9, name_after;
  logic [1:0]       err_close;

  assign closer   = in_end_of_name || in_char_in == CH_DOT || in_char_in == CH_NUL;
  // a closing word waits until the previous label has been replayed
  assign in_stall = closer && busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    room       = LEN_W'(NAME_MAX - 1) - name_cnt_r;
    room_m1    = room - 1'b1;
    label_ext  = LEN_W'(label_cnt_r);
    drop       = (room == '0);
    cut        = !drop && (label_ext > room_m1);
    n9         = cut ? room_m1 : label_ext;
    name_after = drop ? name_cnt_r : name_cnt_r + n9 + 1'b1;
    err_close  = (drop || cut) ? ERR_NAME : err_r;
  end

  always_comb begin
    label_cnt_nxt = label_cnt_r;
    name_cnt_nxt  = name_cnt_r;
    err_nxt       = err_r;
    bank_nxt      = bank_r;
    mem_wr.en     = 1'b0;
    mem_wr.addr   = {bank_r, label_cnt_r};
    mem_wr.data   = in_char_in;
    cmd_push      = 1'b0;
    cmd_data.has_label = !drop;
    cmd_data.n         = CNT_W'(n9);
    cmd_data.bank      = bank_r;
    cmd_data.term      = in_end_of_name;
    cmd_data.enc_len   = name_after + 1'b1;
    cmd_data.err       = err_close;
    if (accept) begin
      if (closer) begin
        cmd_push      = in_end_of_name || !drop;
        label_cnt_nxt = '0;
        bank_nxt      = !bank_r;
        if (in_end_of_name) begin
          name_cnt_nxt = '0;
          err_nxt      = ERR_OK;
        end else begin
          name_cnt_nxt = name_after;
          err_nxt      = err_close;
        end
      end else if (label_cnt_r < CNT_W'(LABEL_MAX)) begin
        mem_wr.en     = 1'b1;
        label_cnt_nxt = label_cnt_r + 1'b1;
      end else if (err_r < ERR_LABEL) begin
        err_nxt = ERR_LABEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_cnt_r <= '0;
      name_cnt_r  <= '0;
      err_r       <= ERR_OK;
      bank_r      <= 1'b0;
    end else begin
      label_cnt_r <= label_cnt_nxt;
      name_cnt_r  <= name_cnt_nxt;
      err_r       <= err_nxt;
      bank_r      <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dnle_cmd_fifo.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module dnle_cmd_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  dnle_pkg::cmd_t  push_data,
  input  wire             pop,
  output dnle_pkg::cmd_t  pop_data,
  output logic            empty
);
  import dnle_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && (cnt_r != 2'd2);
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dnle_back.sv
// Back end: label store and replay sequencer with registered output.
`timescale 1ns / 1ps
`default_nettype none
module dnle_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  dnle_pkg::mem_wr_t      mem_wr,
  input  wire                    fifo_empty,
  input  dnle_pkg::cmd_t         fifo_cmd,
  output logic                   fifo_pop,
  output logic                   back_busy,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  output logic                   out_name_done,
  output logic [8:0]             out_encoded_length,
  output logic [1:0]             out_error_code
);
  import dnle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [7:0] store [2**ADDR_W];
  logic [7:0] rd_data_r;

  logic [1:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             load, emit, at_end;
  logic [7:0]       byte_v;
  logic             last_v, done_v;
  logic [LEN_W-1:0] len_v;
  logic [1:0]       err_v;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r, out_done_r;
  logic [LEN_W-1:0] out_len_r;
  logic [1:0]       out_err_r;

  assign load      = !out_valid_r || !out_stall;
  assign back_busy = (state_r != ST_IDLE);
  assign at_end    = (idx_r == CNT_W'(cmd_r.n - 1'b1));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    fifo_pop  = 1'b0;
    emit      = 1'b0;
    byte_v    = 8'h00;
    last_v    = 1'b0;
    done_v    = 1'b0;
    len_v     = '0;
    err_v     = ERR_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop  = 1'b1;
          cmd_nxt   = fifo_cmd;
          idx_nxt   = '0;
          state_nxt = fifo_cmd.has_label ? ST_LEN : ST_TERM;
        end
      end
      ST_LEN: begin
        if (load) begin
          emit   = 1'b1;
          byte_v = 8'(cmd_r.n);
          last_v = (cmd_r.n == '0) && !cmd_r.term;
          if (cmd_r.n != '0) state_nxt = ST_DATA;
          else state_nxt = cmd_r.term ? ST_TERM : ST_IDLE;
        end
      end
      ST_DATA: begin
        if (load) begin
          emit    = 1'b1;
          byte_v  = rd_data_r;
          last_v  = at_end && !cmd_r.term;
          idx_nxt = idx_r + 1'b1;
          if (at_end) state_nxt = cmd_r.term ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        if (load) begin
          emit      = 1'b1;
          byte_v    = 8'h00;
          last_v    = 1'b1;
          done_v    = 1'b1;
          len_v     = cmd_r.enc_len;
          err_v     = cmd_r.err;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read address follows the next index so rd_data_r matches idx_r
  always_ff @(posedge clk) begin
    if (mem_wr.en) store[mem_wr.addr] <= mem_wr.data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store[{cmd_nxt.bank, idx_nxt}];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      out_byte_r <= byte_v;
      out_last_r <= last_v;
      out_done_r <= done_v;
      out_len_r  <= len_v;
      out_err_r  <= err_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= emit;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_run_last       = out_last_r;
  assign out_name_done      = out_done_r;
  assign out_encoded_length = out_len_r;
  assign out_error_code     = out_err_r;

endmodule
`default_nettype wire

FILE: hdl/dns_name_label_encoder.sv
// DNS name label encoder: top level.
//
// Input channel (in_valid / in_stall): one word per host name character,
// or an end-of-name word. Ordinary characters are written into a two-bank
// label store and are taken one per cycle, with no result.
// A dot, a zero character or an end-of-name word closes the label; the
// front queues a replay command and the back emits the length byte, the
// label characters and, at end of name, the terminator with the encoded
// length and error code.
// Output channel (out_valid / out_stall): one encoded byte per word,
// out_run_last on the last word caused by an input word.
// A closing word's command passes through the queue to the back, which
// then emits one byte per cycle while out_stall is low, and passes
// through idle before the next label's length byte.
// A closing word is stalled while an earlier label is still queued or
// being replayed; characters of the next label go to the other bank
// meanwhile, so the replay sets the rate.
// When out_stall is high the output word holds and the replay waits.
// Synchronous reset clears counts, flags, the queue and out_valid; the
// label store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dns_name_label_encoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_char_in,
  input  wire        in_end_of_name,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_name_done,
  output logic [8:0] out_encoded_length,
  output logic [1:0] out_error_code
);
  import dnle_pkg::*;

  mem_wr_t mem_wr;
  cmd_t    push_cmd, pop_cmd;
  logic    cmd_push, fifo_pop, fifo_empty, back_busy, busy;

  assign busy = !fifo_empty || back_busy;

  dnle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_end_of_name (in_end_of_name),
    .busy           (busy),
    .mem_wr         (mem_wr),
    .cmd_push       (cmd_push),
    .cmd_data       (push_cmd)
  );

  dnle_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_cmd),
    .pop       (fifo_pop),
    .pop_data  (pop_cmd),
    .empty     (fifo_empty)
  );

  dnle_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .mem_wr             (mem_wr),
    .fifo_empty         (fifo_empty),
    .fifo_cmd           (pop_cmd),
    .fifo_pop           (fifo_pop),
    .back_busy          (back_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_run_last       (out_run_last),
    .out_name_done      (out_name_done),
    .out_encoded_length (out_encoded_length),
    .out_error_code     (out_error_code)
  );

endmodule
`default_nettype wire
